// ===== hw/rtl/lcrr_pkg.sv =====
`timescale 1ns / 1ps

package lcrr_pkg;

	localparam int NODE_COUNT   = 8;
	localparam int NODE_BITS    = $clog2(NODE_COUNT);
	localparam int CNT_BITS     = $clog2(NODE_COUNT + 1);
	localparam int QUEUE_DEPTH  = 16;
	localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);
	localparam int PAYLOAD_BITS = 32;
	localparam int TIME_BITS    = 32;
	localparam int HOP_BITS     = 16;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_BITS     = HOP_BITS;
	localparam int ADDR_BITS    = NODE_BITS + QPTR_BITS;
	localparam int RAM_DEPTH    = NODE_COUNT << QPTR_BITS;

	// stream widths, padded to whole bytes
	localparam int S_FIELDS_W = 2 * NODE_BITS + PAYLOAD_BITS;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = 2 + PAYLOAD_BITS + CNT_BITS + 1;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	localparam logic [CFG_IDX_BITS-1:0] CFG_HOP_LATENCY  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_NODES = CFG_IDX_BITS'(1);

	localparam logic [HOP_BITS-1:0] HOP_RESET    = HOP_BITS'(1);
	localparam logic [CNT_BITS-1:0] ACTIVE_RESET = CNT_BITS'(NODE_COUNT);

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_TICK = 2'd1,
		CMD_POP  = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_BAD   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_DECODE,
		FSM_POP_RD,
		FSM_SCAN,
		FSM_RESP
	} fsm_t;

	typedef struct packed {
		logic decode;
		logic pop_data;
		logic scan_issue;
		logic scan_eval;
		logic scan_last;
		logic load_out;
	} ctl_t;

	typedef struct packed {
		logic [TIME_BITS-1:0]    ready;
		logic [NODE_BITS-1:0]    dest;
		logic [PAYLOAD_BITS-1:0] payload;
	} in_entry_t;

	localparam int IN_W = $bits(in_entry_t);

	// (a + b) mod QUEUE_DEPTH for a, b below the depth
	function automatic logic [QPTR_BITS-1:0] q_add(input logic [QPTR_BITS-1:0] a,
		input logic [QPTR_BITS-1:0] b);
		logic [QPTR_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (QPTR_BITS+1)'(QUEUE_DEPTH)) s = s - (QPTR_BITS+1)'(QUEUE_DEPTH);
		return s[QPTR_BITS-1:0];
	endfunction

	// node index modulo the live node count, by repeated subtraction
	function automatic logic [NODE_BITS-1:0] node_mod(input logic [NODE_BITS-1:0] v,
		input logic [CNT_BITS-1:0] n);
		logic [CNT_BITS-1:0] r;
		r = CNT_BITS'(v);
		for (int i = 0; i < NODE_COUNT - 1; i++) begin
			if (r >= n) r = r - n;
		end
		return r[NODE_BITS-1:0];
	endfunction

endpackage

// ===== hw/rtl/lcrr_ram.sv =====
`timescale 1ns / 1ps

module lcrr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/lcrr_ctrl.sv =====
`timescale 1ns / 1ps

module lcrr_ctrl import lcrr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  cmd_t                cmd,
	input  logic [CNT_BITS-1:0] live_n,
	input  logic                out_free,
	output logic                s_tready,
	output ctl_t                ctl
);

	fsm_t                state_q, state_d;
	logic [CNT_BITS-1:0] k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FSM_DECODE) k_q <= '0;
			else if (state_q == FSM_SCAN) k_q <= k_q + CNT_BITS'(1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: if (s_tvalid) state_d = FSM_DECODE;
			FSM_DECODE: begin
				unique case (cmd)
					CMD_PUSH: state_d = FSM_RESP;
					CMD_NOP:  state_d = FSM_RESP;
					CMD_POP:  state_d = FSM_POP_RD;
					CMD_TICK: state_d = FSM_SCAN;
				endcase
			end
			FSM_POP_RD: state_d = FSM_RESP;
			FSM_SCAN: if (k_q == live_n) state_d = FSM_RESP;
			FSM_RESP: if (out_free) state_d = FSM_IDLE;
			default: state_d = FSM_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready       = (state_q == FSM_IDLE);
		ctl.decode     = (state_q == FSM_DECODE);
		ctl.pop_data   = (state_q == FSM_POP_RD);
		ctl.scan_issue = (state_q == FSM_SCAN) && (k_q < live_n);
		ctl.scan_eval  = (state_q == FSM_SCAN) && (k_q != '0);
		ctl.scan_last  = (state_q == FSM_SCAN) && (k_q == live_n);
		ctl.load_out   = (state_q == FSM_RESP) && out_free;
	end

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> ctl.decode)
		else $error("accepted transaction not decoded");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_SCAN |-> k_q <= live_n)
		else $error("scan counter ran past the live node count");

	a_scan_resp: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan_last |=> state_q == FSM_RESP)
		else $error("scan did not finish into response");

endmodule

// ===== hw/rtl/latency_crossbar_round_robin.sv =====
`timescale 1ns / 1ps
// flow: a push or no-op goes from decode to the response; a pop adds a payload read from
//   the output queue ram; a tick scans one source per cycle through the input queue ram read port
// accept: a new transaction is taken only once the previous one has been loaded into the
//   output register; the response waits while that register is still full and not taken
// reset: arst_n clears time, pointer, all queue heads and counts, config to defaults;
//   queue rams are not cleared and need no clearing pass

module latency_crossbar_round_robin import lcrr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// slave side
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [S_TDATA_W-1:0]    s_tdata,   // source_node, target_node, payload, zero pad
	input  logic [1:0]              s_tuser,   // command
	// master side
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [M_TDATA_W-1:0]    m_tdata,   // status, payload_out, moved_count, queue_empty, pad
	output logic                    m_tuser,   // payload_valid
	// configuration
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	ctl_t ctl;

	// configuration registers
	logic [HOP_BITS-1:0] hop_q;
	logic [CNT_BITS-1:0] active_q;
	logic [CNT_BITS-1:0] live_n;

	// captured transaction fields
	cmd_t                    cmd_q;
	logic [NODE_BITS-1:0]    src_in_q;
	logic [NODE_BITS-1:0]    dst_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	// crossbar state
	logic [TIME_BITS-1:0] time_q;
	logic [NODE_BITS-1:0] ptr_q;
	logic [NODE_BITS-1:0] start_q;
	logic [NODE_BITS-1:0] scan_src_q;
	logic [QPTR_BITS-1:0] in_head_q   [NODE_COUNT];
	logic [QCNT_BITS-1:0] in_cnt_q    [NODE_COUNT];
	logic [TIME_BITS-1:0] last_rdy_q  [NODE_COUNT];
	logic [QPTR_BITS-1:0] out_head_q  [NODE_COUNT];
	logic [QCNT_BITS-1:0] out_cnt_q   [NODE_COUNT];
	logic [NODE_COUNT-1:0] taken_q;

	// scan pipeline: issue stage registers
	logic [NODE_BITS-1:0] src_s1;
	logic [QPTR_BITS-1:0] head_s1;
	logic [QCNT_BITS-1:0] cnt_s1;

	// result under construction
	status_t                 res_status_q;
	logic [PAYLOAD_BITS-1:0] res_payload_q;
	logic                    res_pvalid_q;
	logic [CNT_BITS-1:0]     res_moved_q;

	// output register
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic                 m_tuser_q;

	logic                 accept;
	logic                 out_free;
	logic [NODE_BITS-1:0] in_sel;
	logic [NODE_BITS-1:0] out_sel;
	logic [QPTR_BITS-1:0] in_head_rd;
	logic [QCNT_BITS-1:0] in_cnt_rd;
	logic [QPTR_BITS-1:0] out_head_rd;
	logic [QCNT_BITS-1:0] out_cnt_rd;
	logic                 src_bad;
	logic                 dst_bad;
	logic                 in_full;
	logic                 out_empty;
	logic                 push_ok;
	logic                 pop_ok;
	logic [TIME_BITS-1:0] push_rdy;
	in_entry_t            push_entry;
	logic [IN_W-1:0]      in_rdata;
	in_entry_t            ev;
	logic [TIME_BITS-1:0] ev_diff;
	logic                 ev_ready;
	logic                 ev_take;
	logic [NODE_BITS-1:0] ev_dest;
	logic [PAYLOAD_BITS-1:0] out_rdata;
	logic                 q_empty;
	status_t              dec_status;
	logic [NODE_BITS-1:0] start_d;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// out of range active count folds into 1..NODE_COUNT
	always_comb begin
		if (active_q == '0) live_n = CNT_BITS'(1);
		else if (active_q > CNT_BITS'(NODE_COUNT)) live_n = CNT_BITS'(NODE_COUNT);
		else live_n = active_q;
	end

	lcrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.cmd      (cmd_q),
		.live_n   (live_n),
		.out_free (out_free),
		.s_tready (s_tready),
		.ctl      (ctl)
	);

	// one read address per cycle into each bookkeeping array
	assign in_sel      = ctl.scan_issue ? scan_src_q : src_in_q;
	assign in_head_rd  = in_head_q[in_sel];
	assign in_cnt_rd   = in_cnt_q[in_sel];
	assign ev          = in_entry_t'(in_rdata);
	assign ev_dest     = ev.dest;
	assign out_sel     = ctl.scan_eval ? ev_dest : dst_q;
	assign out_head_rd = out_head_q[out_sel];
	assign out_cnt_rd  = out_cnt_q[out_sel];

	assign src_bad   = {1'b0, src_in_q} >= live_n;
	assign dst_bad   = {1'b0, dst_q} >= live_n;
	assign in_full   = in_cnt_rd == QCNT_BITS'(QUEUE_DEPTH);
	assign out_empty = out_cnt_rd == '0;

	// push: ready time from the clock when the queue is empty, else chained on the newest entry
	assign push_rdy = (in_cnt_rd == '0) ? time_q + TIME_BITS'(hop_q)
	                                    : last_rdy_q[src_in_q] + TIME_BITS'(1);
	assign push_ok  = ctl.decode && (cmd_q == CMD_PUSH) && !src_bad && !dst_bad && !in_full;
	assign pop_ok   = ctl.decode && (cmd_q == CMD_POP) && !dst_bad && !out_empty;

	assign push_entry.ready   = push_rdy;
	assign push_entry.dest    = dst_q;
	assign push_entry.payload = pay_q;

	// wrap-safe ready compare: difference zero or negative
	assign ev_diff  = ev.ready - time_q;
	assign ev_ready = (ev_diff == '0) || ev_diff[TIME_BITS-1];
	assign ev_take  = ctl.scan_eval && (cnt_s1 != '0) && ev_ready && !taken_q[ev_dest]
	                  && (out_cnt_rd < QCNT_BITS'(QUEUE_DEPTH));

	assign q_empty = dst_bad || out_empty;
	assign start_d = node_mod(ptr_q, live_n);

	always_comb begin
		dec_status = STAT_OK;
		unique case (cmd_q)
			CMD_PUSH: begin
				if (src_bad || dst_bad) dec_status = STAT_BAD;
				else if (in_full) dec_status = STAT_FULL;
			end
			CMD_POP: begin
				if (dst_bad) dec_status = STAT_BAD;
				else if (out_empty) dec_status = STAT_EMPTY;
			end
			CMD_TICK: dec_status = STAT_OK;
			CMD_NOP:  dec_status = STAT_OK;
		endcase
	end

	// input queues: ready time, destination and payload per entry
	lcrr_ram #(
		.WIDTH (IN_W),
		.DEPTH (RAM_DEPTH)
	) u_in_ram (
		.clk   (clk),
		.we    (push_ok),
		.waddr ({src_in_q, q_add(in_head_rd, in_cnt_rd[QPTR_BITS-1:0])}),
		.wdata (push_entry),
		.re    (ctl.scan_issue),
		.raddr ({scan_src_q, in_head_rd}),
		.rdata (in_rdata)
	);

	// output queues: payload per entry
	lcrr_ram #(
		.WIDTH (PAYLOAD_BITS),
		.DEPTH (RAM_DEPTH)
	) u_out_ram (
		.clk   (clk),
		.we    (ev_take),
		.waddr ({ev_dest, q_add(out_head_rd, out_cnt_rd[QPTR_BITS-1:0])}),
		.wdata (ev.payload),
		.re    (pop_ok),
		.raddr ({dst_q, out_head_rd}),
		.rdata (out_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_q      <= HOP_RESET;
			active_q   <= ACTIVE_RESET;
			time_q     <= '0;
			ptr_q      <= '0;
			start_q    <= '0;
			scan_src_q <= '0;
			taken_q    <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < NODE_COUNT; i++) begin
				in_head_q[i]  <= '0;
				in_cnt_q[i]   <= '0;
				out_head_q[i] <= '0;
				out_cnt_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_HOP_LATENCY) hop_q <= cfg_data[HOP_BITS-1:0];
				if (cfg_index == CFG_ACTIVE_NODES) active_q <= cfg_data[CNT_BITS-1:0];
			end

			if (push_ok) in_cnt_q[src_in_q] <= in_cnt_rd + QCNT_BITS'(1);

			if (pop_ok) begin
				out_head_q[dst_q] <= q_add(out_head_rd, QPTR_BITS'(1));
				out_cnt_q[dst_q]  <= out_cnt_rd - QCNT_BITS'(1);
			end

			// tick start: clear the per-destination grant mask, align the pointer
			if (ctl.decode && (cmd_q == CMD_TICK)) begin
				taken_q    <= '0;
				start_q    <= start_d;
				scan_src_q <= start_d;
			end

			if (ctl.scan_issue) begin
				if (CNT_BITS'(scan_src_q) + CNT_BITS'(1) == live_n) scan_src_q <= '0;
				else scan_src_q <= scan_src_q + NODE_BITS'(1);
			end

			// move one ready head to its destination
			if (ev_take) begin
				in_head_q[src_s1]  <= q_add(head_s1, QPTR_BITS'(1));
				in_cnt_q[src_s1]   <= cnt_s1 - QCNT_BITS'(1);
				out_cnt_q[ev_dest] <= out_cnt_rd + QCNT_BITS'(1);
				taken_q[ev_dest]   <= 1'b1;
			end

			if (ctl.scan_last) begin
				if (CNT_BITS'(start_q) + CNT_BITS'(1) == live_n) ptr_q <= '0;
				else ptr_q <= start_q + NODE_BITS'(1);
				time_q <= time_q + TIME_BITS'(1);
			end

			if (ctl.load_out) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd_t'(s_tuser);
			src_in_q <= s_tdata[NODE_BITS-1:0];
			dst_q    <= s_tdata[2*NODE_BITS-1:NODE_BITS];
			pay_q    <= s_tdata[2*NODE_BITS+PAYLOAD_BITS-1:2*NODE_BITS];
		end

		if (push_ok) last_rdy_q[src_in_q] <= push_rdy;

		if (ctl.decode) begin
			res_status_q  <= dec_status;
			res_pvalid_q  <= pop_ok;
			res_payload_q <= '0;
			res_moved_q   <= '0;
		end else begin
			if (ctl.pop_data && res_pvalid_q) res_payload_q <= out_rdata;
			if (ev_take) res_moved_q <= res_moved_q + CNT_BITS'(1);
		end

		if (ctl.scan_issue) begin
			src_s1  <= scan_src_q;
			head_s1 <= in_head_rd;
			cnt_s1  <= in_cnt_rd;
		end

		// queue_empty reflects the settled state of the named output queue
		if (ctl.load_out) begin
			m_tdata_q <= M_TDATA_W'({q_empty, res_moved_q, res_payload_q, res_status_q});
			m_tuser_q <= res_pvalid_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_time_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan_last |=> time_q == $past(time_q) + TIME_BITS'(1))
		else $error("tick did not advance time by one");

	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[1:0] == STAT_OK)
		else $error("popped payload with a failure status");

	a_moved_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> res_moved_q <= live_n)
		else $error("more moves than live sources");

	a_take_single: assert property (@(posedge clk) disable iff (!arst_n)
		ev_take |=> taken_q[$past(ev_dest)])
		else $error("grant mask not set after a move");

endmodule
